>>> design/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types, sizes and codes of the two-level cache tag simulator.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int L1_SETS          = 512;
    localparam int L2_SETS          = 4096;
    localparam int LINE_OFFSET_BITS = 6;
    localparam int ADDR_BITS        = 48;

    localparam int LINE_BITS   = ADDR_BITS - LINE_OFFSET_BITS;
    localparam int L1_SET_BITS = $clog2(L1_SETS);
    localparam int L2_SET_BITS = $clog2(L2_SETS);
    localparam int L1_TAG_BITS = LINE_BITS - L1_SET_BITS;
    localparam int L2_TAG_BITS = LINE_BITS - L2_SET_BITS;

    // One row per (kind, set): the kind bit sits above the set index.
    localparam int L1_ROWS     = 2 * L1_SETS;
    localparam int L2_ROWS     = 2 * L2_SETS;
    localparam int L1_ROW_BITS = L1_SET_BITS + 1;
    localparam int L2_ROW_BITS = L2_SET_BITS + 1;

    localparam int CLEAR_ROWS = (L1_ROWS > L2_ROWS) ? L1_ROWS : L2_ROWS;
    localparam int CLEAR_BITS = $clog2(CLEAR_ROWS);

    localparam logic [1:0] LEVEL_L1   = 2'd0;
    localparam logic [1:0] LEVEL_L2   = 2'd1;
    localparam logic [1:0] LEVEL_MISS = 2'd2;

    typedef struct packed {
        logic [ADDR_BITS-1:0] byte_address;
        logic                 access_kind;
    } request_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] hit_level;
    } result_t;

    typedef struct packed {
        logic                   valid;
        logic [L1_TAG_BITS-1:0] tag;
    } l1_way_t;

    typedef struct packed {
        logic                   valid;
        logic [L2_TAG_BITS-1:0] tag;
    } l2_way_t;

    // recent holds the number of the most recently used way.
    typedef struct packed {
        logic             recent;
        l1_way_t [1:0]    ways;
    } l1_row_t;

    typedef struct packed {
        logic             recent;
        l2_way_t [1:0]    ways;
    } l2_row_t;

endpackage

>>> design/tlc_ram.sv
// ----------------------------------------------------------------------------
// tlc_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/two_level_cache_tag_simulator_unit.sv
// ----------------------------------------------------------------------------
// two_level_cache_tag_simulator_unit
// Tag-only model of split instruction and data hierarchies, each with a
// two-way L1 and a two-way L2 and one LRU bit per set.
// ----------------------------------------------------------------------------
// Usage. A transaction is accepted at a rising edge where start is high and
// busy is low; request carries the byte address and the access kind. The
// outcome appears on result, marked by done for exactly one cycle, and the
// receiver has no means to hold it off.
// Timing. The edge that accepts a transaction also launches the reads of the
// L1 row and the L2 row. In the following cycle the tags are compared, the L1
// row is written back, and so is the L2 row when the L1 missed; busy is high
// for that cycle only. done is high in the cycle after that. No new transaction is
// taken while the last one is being looked up and written back; the limit is set
// by the read-modify-write of the tag RAMs, which have one read and one write port.
// Reset. After rst_n is released the block clears both tag RAMs, one row of
// each per cycle, over CLEAR_ROWS row addresses (8192 at the default sizes), with
// busy held high throughout.
// ----------------------------------------------------------------------------
module two_level_cache_tag_simulator_unit
    import tlc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    logic                   clearing_reg, clearing_next;
    logic [CLEAR_BITS-1:0]  clear_count_reg, clear_count_next;
    logic                   pending_reg, pending_next;
    logic                   done_reg, done_next;
    result_t                result_reg, result_next;

    logic [L1_ROW_BITS-1:0] row1_reg;
    logic [L2_ROW_BITS-1:0] row2_reg;
    logic [L1_TAG_BITS-1:0] tag1_reg;
    logic [L2_TAG_BITS-1:0] tag2_reg;

    logic [LINE_BITS-1:0]   line;
    logic [L1_ROW_BITS-1:0] row1;
    logic [L2_ROW_BITS-1:0] row2;
    logic                   accept;

    l1_row_t                l1_rdata, l1_wdata, l1_upd;
    l2_row_t                l2_rdata, l2_wdata, l2_upd;
    logic                   l1_we, l2_we;
    logic [L1_ROW_BITS-1:0] l1_waddr;
    logic [L2_ROW_BITS-1:0] l2_waddr;

    logic                   l1_hit0, l1_hit1, l1_hit;
    logic                   l2_hit0, l2_hit1, l2_hit;
    logic                   l1_victim, l2_victim;

    assign accept = start && !busy;
    assign busy   = clearing_reg || pending_reg;
    assign done   = done_reg;
    assign result = result_reg;

    assign line = request.byte_address[ADDR_BITS-1:LINE_OFFSET_BITS];
    assign row1 = {request.access_kind, line[L1_SET_BITS-1:0]};
    assign row2 = {request.access_kind, line[L2_SET_BITS-1:0]};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row1_reg <= row1;
            row2_reg <= row2;
            tag1_reg <= line[LINE_BITS-1:L1_SET_BITS];
            tag2_reg <= line[LINE_BITS-1:L2_SET_BITS];
        end
    end

    // Lookup and update of the rows read for the pending transaction.
    always_comb
    begin
        l1_hit0 = l1_rdata.ways[0].valid && (l1_rdata.ways[0].tag == tag1_reg);
        l1_hit1 = l1_rdata.ways[1].valid && (l1_rdata.ways[1].tag == tag1_reg);
        l1_hit  = l1_hit0 || l1_hit1;
        l2_hit0 = l2_rdata.ways[0].valid && (l2_rdata.ways[0].tag == tag2_reg);
        l2_hit1 = l2_rdata.ways[1].valid && (l2_rdata.ways[1].tag == tag2_reg);
        l2_hit  = l2_hit0 || l2_hit1;
        l1_victim = ~l1_rdata.recent;
        l2_victim = ~l2_rdata.recent;

        l1_upd = l1_rdata;
        if (l1_hit)
        begin
            l1_upd.recent = !l1_hit0;
        end
        else
        begin
            l1_upd.recent                = l1_victim;
            l1_upd.ways[l1_victim].valid = 1'b1;
            l1_upd.ways[l1_victim].tag   = tag1_reg;
        end

        l2_upd = l2_rdata;
        if (l2_hit)
        begin
            l2_upd.recent = !l2_hit0;
        end
        else
        begin
            l2_upd.recent                = l2_victim;
            l2_upd.ways[l2_victim].valid = 1'b1;
            l2_upd.ways[l2_victim].tag   = tag2_reg;
        end
    end

    // Write ports serve the clearing pass after reset, then the write-back.
    always_comb
    begin
        if (clearing_reg)
        begin
            l1_we    = ({1'b0, clear_count_reg} < (CLEAR_BITS + 1)'(L1_ROWS));
            l2_we    = ({1'b0, clear_count_reg} < (CLEAR_BITS + 1)'(L2_ROWS));
            l1_waddr = clear_count_reg[L1_ROW_BITS-1:0];
            l2_waddr = clear_count_reg[L2_ROW_BITS-1:0];
            l1_wdata = '0;
            l2_wdata = '0;
        end
        else
        begin
            l1_we    = pending_reg;
            l2_we    = pending_reg && !l1_hit;
            l1_waddr = row1_reg;
            l2_waddr = row2_reg;
            l1_wdata = l1_upd;
            l2_wdata = l2_upd;
        end
    end

    always_comb
    begin
        clearing_next    = clearing_reg;
        clear_count_next = clear_count_reg;
        pending_next     = accept;
        done_next        = pending_reg;
        result_next      = result_reg;

        if (clearing_reg)
        begin
            clear_count_next = clear_count_reg + CLEAR_BITS'(1);
            if (clear_count_reg == CLEAR_BITS'(CLEAR_ROWS - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        if (pending_reg)
        begin
            if (l1_hit)
            begin
                result_next.hit       = 1'b1;
                result_next.hit_level = LEVEL_L1;
            end
            else if (l2_hit)
            begin
                result_next.hit       = 1'b1;
                result_next.hit_level = LEVEL_L2;
            end
            else
            begin
                result_next.hit       = 1'b0;
                result_next.hit_level = LEVEL_MISS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg    <= 1'b1;
            clear_count_reg <= '0;
            pending_reg     <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            clearing_reg    <= clearing_next;
            clear_count_reg <= clear_count_next;
            pending_reg     <= pending_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    tlc_ram #(
        .WIDTH ($bits(l1_row_t)),
        .DEPTH (L1_ROWS)
    ) u_l1_ram (
        .clk   (clk),
        .we    (l1_we),
        .waddr (l1_waddr),
        .wdata (l1_wdata),
        .re    (accept),
        .raddr (row1),
        .rdata (l1_rdata)
    );

    tlc_ram #(
        .WIDTH ($bits(l2_row_t)),
        .DEPTH (L2_ROWS)
    ) u_l2_ram (
        .clk   (clk),
        .we    (l2_we),
        .waddr (l2_waddr),
        .wdata (l2_wdata),
        .re    (accept),
        .raddr (row2),
        .rdata (l2_rdata)
    );

    // Every result strobe follows an accepted transaction, through pending_reg and then done_reg.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result strobe without a matching transaction");

    // The hit flag agrees with the level that was reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.hit == (result.hit_level != LEVEL_MISS)))
        else $error("hit flag disagrees with hit level");

    // No transaction is in flight while the clearing pass owns the RAMs.
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !pending_reg)
        else $error("transaction accepted during clearing pass");

    // The L2 row is only written back when the L1 lookup missed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg && l2_we) |-> (!l1_hit && l1_we))
        else $error("L2 written back on an L1 hit");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-level cache tag simulator. A queue of
// accesses feeds a clocked driver. Each accepted transaction is run through
// a local tag-store predictor, and a monitor compares every result with the
// oldest predicted outcome.
// ----------------------------------------------------------------------------
module tb_top
    import tlc_pkg::*;
();

    typedef struct {
        request_t    req;
        int unsigned idle_pct;
        bit          hold_for_drain;
    } pending_access_t;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    pending_access_t access_queue[$];
    result_t         expected_outcomes[$];
    int unsigned     mismatch_count = 0;

    // Predictor state, indexed by access kind, then set, then way.
    bit                   l1_valid [2][L1_SETS][2];
    bit [L1_TAG_BITS-1:0] l1_tag   [2][L1_SETS][2];
    bit                   l1_mru   [2][L1_SETS];
    bit                   l2_valid [2][L2_SETS][2];
    bit [L2_TAG_BITS-1:0] l2_tag   [2][L2_SETS][2];
    bit                   l2_mru   [2][L2_SETS];

    two_level_cache_tag_simulator_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Looks up one access in L1, and in L2 when L1 misses, updates the LRU bits
    // and fills missing lines, and returns where the line was found.
    function automatic result_t predict_lookup(request_t req);
        logic [LINE_BITS-1:0]   line;
        logic                   kind;
        logic [L1_SET_BITS-1:0] s1;
        logic [L2_SET_BITS-1:0] s2;
        logic [L1_TAG_BITS-1:0] t1;
        logic [L2_TAG_BITS-1:0] t2;
        bit                     found1;
        bit                     found2;
        bit                     victim;
        result_t                outcome;

        line   = req.byte_address[ADDR_BITS-1:LINE_OFFSET_BITS];
        kind   = req.access_kind;
        s1     = line[L1_SET_BITS-1:0];
        t1     = line[LINE_BITS-1:L1_SET_BITS];
        s2     = line[L2_SET_BITS-1:0];
        t2     = line[LINE_BITS-1:L2_SET_BITS];
        found1 = 1'b0;
        found2 = 1'b0;

        for (int w = 0; w < 2; w++)
        begin
            if (!found1 && l1_valid[kind][s1][w] && l1_tag[kind][s1][w] == t1)
            begin
                found1            = 1'b1;
                l1_mru[kind][s1]  = w[0];
            end
        end

        if (!found1)
        begin
            for (int w = 0; w < 2; w++)
            begin
                if (!found2 && l2_valid[kind][s2][w] && l2_tag[kind][s2][w] == t2)
                begin
                    found2           = 1'b1;
                    l2_mru[kind][s2] = w[0];
                end
            end
            victim                    = ~l1_mru[kind][s1];
            l1_valid[kind][s1][victim] = 1'b1;
            l1_tag[kind][s1][victim]   = t1;
            l1_mru[kind][s1]           = victim;
            if (!found2)
            begin
                victim                     = ~l2_mru[kind][s2];
                l2_valid[kind][s2][victim] = 1'b1;
                l2_tag[kind][s2][victim]   = t2;
                l2_mru[kind][s2]           = victim;
            end
        end

        outcome.hit       = found1 || found2;
        outcome.hit_level = found1 ? LEVEL_L1 : (found2 ? LEVEL_L2 : LEVEL_MISS);
        return outcome;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic add_access(input logic [ADDR_BITS-1:0] addr, input logic kind,
                              input int unsigned idle_pct, input bit hold);
        pending_access_t item;

        item.req.byte_address = addr;
        item.req.access_kind  = kind;
        item.idle_pct         = idle_pct;
        item.hold_for_drain   = hold;
        access_queue = {access_queue, item};
    endtask

    function automatic logic [ADDR_BITS-1:0] random_address();
        return ADDR_BITS'({$urandom, $urandom});
    endfunction

    // Driver: predicts each transaction at the edge that accepts it, then presents the
    // next queued access unless the queue is empty, a drain is awaited or the sender idles.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                expected_outcomes = {expected_outcomes, predict_lookup(request)};
            if (!start || !busy)
            begin
                if (access_queue.size() == 0)
                    start <= 1'b0;
                else if (access_queue[0].hold_for_drain && (expected_outcomes.size() != 0))
                    start <= 1'b0;
                else if ($urandom_range(99) < access_queue[0].idle_pct)
                    start <= 1'b0;
                else
                begin
                    start   <= 1'b1;
                    request <= access_queue[0].req;
                    access_queue.pop_front();
                end
            end
        end
    end

    // Monitor: results change on rising edges, so they are sampled mid-cycle.
    always @(negedge clk)
    begin
        result_t want;

        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                report_mismatch($sformatf("result %0b/%0d with no access outstanding",
                                          result.hit, result.hit_level));
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (result.hit !== want.hit)
                    report_mismatch($sformatf("hit %b, expected %b", result.hit, want.hit));
                if (result.hit_level !== want.hit_level)
                    report_mismatch($sformatf("hit_level %0d, expected %0d",
                                              result.hit_level, want.hit_level));
            end
        end
    end

    initial
    begin
        logic [LINE_BITS-1:0]   line;
        logic [ADDR_BITS-1:0]   hot_lines [32];
        logic [L1_SET_BITS-1:0] crowded_sets [4];
        logic [L2_TAG_BITS-1:0] crowded_tags [3];
        int unsigned            phase_idle [4];
        int unsigned            pick;

        phase_idle = '{0, 61, 24, 0};
        foreach (hot_lines[i])
            hot_lines[i] = random_address();
        foreach (crowded_sets[i])
            crowded_sets[i] = L1_SET_BITS'($urandom);
        foreach (crowded_tags[i])
            crowded_tags[i] = L2_TAG_BITS'({$urandom, $urandom});

        // Directed part. One L1 set is 32 KiB apart, one L2 set 256 KiB.
        add_access(48'h0000_0000_0000, 1'b0, 0, 1'b0);  // empty set, fills way 1
        add_access(48'h0000_0000_0000, 1'b0, 0, 1'b0);
        add_access(48'h0000_0000_003F, 1'b0, 0, 1'b0);  // offset bits ignored
        add_access(48'h0000_0000_0000, 1'b1, 0, 1'b0);  // data side is separate
        add_access(48'hFFFF_FFFF_FFFF, 1'b1, 0, 1'b0);
        add_access(48'hFFFF_FFFF_FFC0, 1'b1, 0, 1'b0);
        add_access(48'hFFFF_FFFF_FFFF, 1'b0, 0, 1'b0);
        add_access(48'h0000_0000_8000, 1'b0, 0, 1'b0);
        add_access(48'h0000_0001_0000, 1'b0, 0, 1'b0);  // evicts line 0 from L1
        add_access(48'h0000_0000_8000, 1'b0, 0, 1'b0);  // hit in the older way
        add_access(48'h0000_0000_0000, 1'b0, 0, 1'b0);  // L2 hit, evicts 0x10000
        add_access(48'h0000_0000_8000, 1'b0, 0, 1'b0);  // still held after the swap
        add_access(48'h0000_0001_0000, 1'b0, 0, 1'b0);
        add_access(48'h0000_0004_0000, 1'b0, 0, 1'b0);  // same L2 set as line 0
        add_access(48'h0000_0008_0000, 1'b0, 0, 1'b0);
        add_access(48'h0000_000C_0000, 1'b0, 0, 1'b0);
        add_access(48'h0000_0000_0000, 1'b0, 0, 1'b0);
        add_access(48'h0000_0004_0000, 1'b0, 0, 1'b0);
        add_access(48'hAAAA_AAAA_AAAA, 1'b1, 0, 1'b0);
        add_access(48'h5555_5555_5555, 1'b1, 0, 1'b0);
        add_access(48'h8000_0000_0000, 1'b0, 0, 1'b0);

        // Random part: mostly a hot working set and a few crowded sets, so
        // that L1 hits, L2 hits and evictions all occur; the rest is noise.
        for (int p = 0; p < 4; p++)
        begin
            for (int i = 0; i < 158; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                begin
                    line = hot_lines[$urandom_range(31)][ADDR_BITS-1:LINE_OFFSET_BITS];
                end
                else if (pick < 80)
                begin
                    line[L1_SET_BITS-1:0]           = crowded_sets[$urandom_range(3)];
                    line[L2_SET_BITS-1:L1_SET_BITS] = (L2_SET_BITS - L1_SET_BITS)'($urandom);
                    line[LINE_BITS-1:L2_SET_BITS]   = crowded_tags[$urandom_range(2)];
                end
                else
                begin
                    line = LINE_BITS'(random_address() >> LINE_OFFSET_BITS);
                end
                add_access({line, LINE_OFFSET_BITS'($urandom)}, 1'($urandom),
                           phase_idle[p], (p != 0) && (i == 0));
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (access_queue.size() != 0 || start)
            @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
